### sv/task_runtime_stats_table_defines.svh
// Assertion macros shared by the task run-time statistics table RTL.
// Self-contained; each macro is empty when ASSERT_OFF is defined.
`ifndef TASK_RUNTIME_STATS_TABLE_DEFINES_SVH
`define TASK_RUNTIME_STATS_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define TRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define TRS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRS_ASSERT(name, prop, msg)
`define TRS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### sv/trs_pkg.sv
// Types, constants and table geometry for the task run-time statistics table.
// No dependencies; used by the ALU, the table and the top level.
package trs_pkg;

  localparam int TABLE_ENTRIES = 10;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [31:0] MIN_INIT = 32'hFFFF_FFFF;

  // Result status codes
  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_NEW  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [7:0]  task_key;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] duration;
    logic [31:0] total_time;
    logic [31:0] min_time;
    logic [31:0] max_time;
    logic [31:0] run_count;
  } out_word_t;

  // One table row
  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] total;
    logic [31:0] min;
    logic [31:0] max;
    logic [31:0] count;
  } entry_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

endpackage

### sv/trs_alu.sv
// Shared 32-bit add/subtract unit; the borrow of a subtract serves as
// the unsigned less-than flag. Depends on trs_pkg.
module trs_alu (
  input  trs_pkg::alu_req_t req,
  output logic [31:0]       sum,
  output logic              lt
);

  logic [31:0] b_eff;
  logic        cin;
  logic [32:0] full;

  // Invert b and carry in for subtract
  always_comb begin
    case (req.op)
      trs_pkg::ALU_ADD: begin
        b_eff = req.b;
        cin   = 1'b0;
      end
      trs_pkg::ALU_SUB: begin
        b_eff = ~req.b;
        cin   = 1'b1;
      end
      default: begin
        b_eff = req.b;
        cin   = 1'b0;
      end
    endcase
  end

  assign full = {1'b0, req.a} + {1'b0, b_eff} + {32'b0, cin};
  assign sum  = full[31:0];
  // a < b exactly when the subtract borrows
  assign lt   = (req.op == trs_pkg::ALU_SUB) && !full[32];

endmodule

### sv/trs_table.sv
// Statistics table storage: one write port, one read port with registered data.
// Depends on trs_pkg.
module trs_table (
  input  logic                        clk,
  input  logic                        we,
  input  logic [trs_pkg::IDX_W-1:0]   waddr,
  input  trs_pkg::entry_t             wdata,
  input  logic [trs_pkg::IDX_W-1:0]   raddr,
  output trs_pkg::entry_t             rdata
);

  trs_pkg::entry_t mem [trs_pkg::TABLE_ENTRIES];

  // Write the updated row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read row
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/task_runtime_stats_table.sv
// Task run-time statistics table: top level with the sequencer; depends on trs_pkg,
//   trs_alu, trs_table and task_runtime_stats_table_defines.svh.
// Sequence: subtract, scan the used rows for the key, then the add, min, max and count steps,
//   done strobing after the count step; a sample that finds the table full is dropped after the scan.
// A new word is accepted only in idle, once the last is done; one row read per scan cycle,
//   four update passes through the one 32-bit adder. Synchronous reset empties the table.
`include "task_runtime_stats_table_defines.svh"

module task_runtime_stats_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  trs_pkg::in_word_t  item,
  output logic               busy,
  output logic               done,
  output trs_pkg::out_word_t result
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SUB    = 7'b0000010,
    ST_SEARCH = 7'b0000100,
    ST_ADD    = 7'b0001000,
    ST_MIN    = 7'b0010000,
    ST_MAX    = 7'b0100000,
    ST_CNT    = 7'b1000000
  } state_t;

  state_t                      state;
  logic [trs_pkg::CNT_W-1:0]   used;
  logic [trs_pkg::CNT_W-1:0]   idx;
  logic [trs_pkg::CNT_W-1:0]   idx_plus;
  logic [trs_pkg::CNT_W-1:0]   slot_idx;
  logic [trs_pkg::CNT_W+3:0]   slot_wide;
  logic [1:0]                  status;
  trs_pkg::in_word_t           job;
  logic [31:0]                 dur;
  trs_pkg::entry_t             rec;

  trs_pkg::alu_req_t           alu_req;
  logic [31:0]                 alu_sum;
  logic                        alu_lt;

  logic                        mem_we;
  logic [trs_pkg::IDX_W-1:0]   mem_raddr;
  trs_pkg::entry_t             mem_wdata;
  trs_pkg::entry_t             mem_rdata;

  trs_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  trs_table u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_idx[trs_pkg::IDX_W-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign idx_plus  = idx + 1'b1;
  assign slot_wide = {4'b0, slot_idx};

  // Read ahead one row while scanning; row 0 is fetched in the subtract step
  always_comb begin
    if (state == ST_SEARCH) begin
      mem_raddr = idx_plus[trs_pkg::IDX_W-1:0];
    end else begin
      mem_raddr = '0;
    end
  end

  // Write back the finished row in the count step
  assign mem_we    = (state == ST_CNT);
  assign mem_wdata = '{key: rec.key, total: rec.total, min: rec.min,
                       max: rec.max, count: alu_sum};

  // Drive the shared adder for each step
  always_comb begin
    case (state)
      ST_SUB: alu_req = '{op: trs_pkg::ALU_SUB, a: job.end_time, b: job.start_time};
      ST_ADD: alu_req = '{op: trs_pkg::ALU_ADD, a: rec.total, b: dur};
      ST_MIN: alu_req = '{op: trs_pkg::ALU_SUB, a: dur, b: rec.min};
      ST_MAX: alu_req = '{op: trs_pkg::ALU_SUB, a: rec.max, b: dur};
      ST_CNT: alu_req = '{op: trs_pkg::ALU_ADD, a: rec.count, b: 32'd1};
      default: alu_req = '{op: trs_pkg::ALU_ADD, a: 32'd0, b: 32'd0};
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            job   <= item;
            idx   <= '0;
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          dur   <= alu_sum;
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (idx == used) begin
            if (used == trs_pkg::CNT_W'(trs_pkg::TABLE_ENTRIES)) begin
              // Drop the sample: table full
              result <= '{status: trs_pkg::STATUS_FULL, slot: 4'd0, duration: dur,
                          total_time: 32'd0, min_time: 32'd0, max_time: 32'd0,
                          run_count: 32'd0};
              done   <= 1'b1;
              state  <= ST_IDLE;
            end else begin
              // Append a fresh row
              rec      <= '{key: job.task_key, total: 32'd0, min: trs_pkg::MIN_INIT,
                            max: 32'd0, count: 32'd0};
              slot_idx <= used;
              used     <= used + 1'b1;
              status   <= trs_pkg::STATUS_NEW;
              state    <= ST_ADD;
            end
          end else if (mem_rdata.key == job.task_key) begin
            rec      <= mem_rdata;
            slot_idx <= idx;
            status   <= trs_pkg::STATUS_HIT;
            state    <= ST_ADD;
          end else begin
            idx <= idx_plus;
          end
        end
        ST_ADD: begin
          rec.total <= alu_sum;
          state     <= ST_MIN;
        end
        ST_MIN: begin
          if (alu_lt) begin
            rec.min <= dur;
          end
          state <= ST_MAX;
        end
        ST_MAX: begin
          if (alu_lt) begin
            rec.max <= dur;
          end
          state <= ST_CNT;
        end
        ST_CNT: begin
          result <= '{status: status, slot: slot_wide[3:0], duration: dur,
                      total_time: rec.total, min_time: rec.min, max_time: rec.max,
                      run_count: alu_sum};
          done   <= 1'b1;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `TRS_ASSERT_ALWAYS(a_done_in_idle, done |-> (state == ST_IDLE), "done outside idle")
  `TRS_ASSERT(a_accept_starts, (start && !busy) |=> (state == ST_SUB), "accepted word not started")
  `TRS_ASSERT(a_scan_bound, (state == ST_SEARCH) |-> (idx <= used), "scan past used rows")
  `TRS_ASSERT(a_new_grows, (state == ST_SEARCH && idx == used && used != trs_pkg::CNT_W'(trs_pkg::TABLE_ENTRIES)) |=> (used == $past(used) + 1'b1), "new row did not bump used count")
  `TRS_ASSERT(a_full_drop, (done && result.status == trs_pkg::STATUS_FULL) |-> (used == trs_pkg::CNT_W'(trs_pkg::TABLE_ENTRIES)), "drop with room left")

endmodule
